/* src/grb_pkg.sv */
// Shared types and constants for the group reverse buffer.
package grb_pkg;

  localparam int unsigned GsWidth = 7;
  localparam logic [GsWidth-1:0] GsReset = 7'd1;

  // Drain command flags: rev selects a reversed drain, fin tags the stream end.
  typedef struct packed {
    logic rev;
    logic fin;
  } drain_t;

endpackage

/* src/grb_in_if.sv */
// Input stream channel: valid/ready handshake with value and last.
interface grb_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

/* src/grb_out_if.sv */
// Output stream channel: valid/ready handshake with reordered word.
interface grb_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_res;
  logic                         last_res;

  modport source (output valid, output value_res, output last_res, input ready);
  modport sink   (input valid, input value_res, input last_res, output ready);
endinterface

/* src/group_reverse_buffer.sv */
// Group reverse buffer: reverses a word stream in groups of group_size; a short last group drains in order.
// The first drained word passes the command queue and the sequencer to the output.
// Throughput: words that only fill the store go back to back; input is held off
// while a drain is queued or running.
// Reset clears the fill count, the command queue and the output valid and last flags;
// group_size resets to 1. The group store and the output word are not cleared.
module group_reverse_buffer #(
  parameter int unsigned MAX_GROUP  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [grb_pkg::GsWidth-1:0] cfg_wdata_i,
  grb_in_if.sink                      in_s,
  grb_out_if.source                   out_m
);

  localparam int unsigned CntW  = $clog2(MAX_GROUP + 1);
  localparam int unsigned AddrW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CmdW  = $bits(grb_pkg::drain_t) + CntW;

  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  cmd_push;
  grb_pkg::drain_t       push_flags;
  logic [CntW-1:0]       push_cnt;
  logic                  cmd_valid;
  logic [CmdW-1:0]       cmd_word;
  grb_pkg::drain_t       pop_flags;
  logic [CntW-1:0]       pop_cnt;
  logic                  cmd_pop;
  logic                  back_busy;
  logic                  busy;

  assign busy = back_busy || cmd_valid;

  grb_front #(
    .MAX_GROUP  (MAX_GROUP),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_s        (in_s),
    .busy_i      (busy),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .cmd_push_o  (cmd_push),
    .cmd_flags_o (push_flags),
    .cmd_cnt_o   (push_cnt)
  );

  grb_cmd_fifo #(
    .WIDTH (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  ({push_flags, push_cnt}),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_word)
  );

  assign pop_flags = grb_pkg::drain_t'(cmd_word[CmdW-1:CntW]);
  assign pop_cnt   = cmd_word[CntW-1:0];

  grb_back #(
    .MAX_GROUP  (MAX_GROUP),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .cmd_valid_i (cmd_valid),
    .cmd_flags_i (pop_flags),
    .cmd_cnt_i   (pop_cnt),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (back_busy),
    .out_m       (out_m)
  );

endmodule

/* src/grb_front.sv */
// Front end: config register, fill counter, group store writes, drain decisions.
module grb_front #(
  parameter int unsigned MAX_GROUP  = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CntW      = $clog2(MAX_GROUP + 1),
  localparam int unsigned AddrW     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [grb_pkg::GsWidth-1:0]      cfg_wdata_i,
  grb_in_if.sink                           in_s,
  input  logic                             busy_i,
  output logic                             wr_en_o,
  output logic [AddrW-1:0]                 wr_addr_o,
  output logic [DATA_WIDTH-1:0]            wr_data_o,
  output logic                             cmd_push_o,
  output grb_pkg::drain_t                  cmd_flags_o,
  output logic [CntW-1:0]                  cmd_cnt_o
);

  logic [grb_pkg::GsWidth-1:0] group_size_q;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             k_eff;
  logic [CntW-1:0]             fill_inc;
  logic                        accept;
  logic                        drain_rev;
  logic                        drain_fwd;

  // Zero means one, anything above the store depth is clamped.
  always_comb begin
    if (group_size_q == '0) begin
      k_eff = CntW'(1);
    end else if (32'(group_size_q) > MAX_GROUP) begin
      k_eff = CntW'(MAX_GROUP);
    end else begin
      k_eff = CntW'(group_size_q);
    end
  end

  assign in_s.ready = !busy_i;
  assign accept     = in_s.valid && in_s.ready;
  assign fill_inc   = fill_q + CntW'(1);
  assign drain_rev  = fill_inc >= k_eff;
  assign drain_fwd  = !drain_rev && in_s.last;

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = (drain_rev || drain_fwd) ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= grb_pkg::GsReset;
      fill_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
    end
  end

  assign wr_en_o         = accept;
  assign wr_addr_o       = fill_q[AddrW-1:0];
  assign wr_data_o       = in_s.value;
  assign cmd_push_o      = accept && (drain_rev || drain_fwd);
  assign cmd_flags_o.rev = drain_rev;
  assign cmd_flags_o.fin = in_s.last;
  assign cmd_cnt_o       = fill_inc;

endmodule

/* src/grb_cmd_fifo.sv */
// Two-entry queue of drain commands between front and back.
module grb_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wp_q;
  logic             rp_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rp_q];
  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/grb_back.sv */
// Back end: group store and drain sequencer feeding the output register.
module grb_back #(
  parameter int unsigned MAX_GROUP  = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CntW      = $clog2(MAX_GROUP + 1),
  localparam int unsigned AddrW     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic                  cmd_valid_i,
  input  grb_pkg::drain_t       cmd_flags_i,
  input  logic [CntW-1:0]       cmd_cnt_i,
  output logic                  cmd_pop_o,
  output logic                  busy_o,
  grb_out_if.source             out_m
);

  logic [DATA_WIDTH-1:0] store_q [MAX_GROUP];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  active_q;
  logic                  rev_q;
  logic                  fin_q;
  logic [CntW-1:0]       rem_q;
  logic [AddrW-1:0]      addr_q;
  logic                  ov_q;
  logic                  ol_q;
  logic                  out_free;
  logic                  issue;
  logic                  pop;

  assign out_free  = !ov_q || out_m.ready;
  assign issue     = active_q && out_free;
  assign pop       = !active_q && cmd_valid_i;
  assign cmd_pop_o = pop;
  assign busy_o    = active_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data register doubles as the output word; it only moves on issue.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= store_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rev_q    <= 1'b0;
      fin_q    <= 1'b0;
      rem_q    <= '0;
      addr_q   <= '0;
      ov_q     <= 1'b0;
      ol_q     <= 1'b0;
    end else begin
      if (pop) begin
        active_q <= 1'b1;
        rev_q    <= cmd_flags_i.rev;
        fin_q    <= cmd_flags_i.fin;
        rem_q    <= cmd_cnt_i;
        addr_q   <= cmd_flags_i.rev ? AddrW'(cmd_cnt_i - CntW'(1)) : '0;
      end else if (issue) begin
        rem_q  <= rem_q - CntW'(1);
        addr_q <= rev_q ? addr_q - AddrW'(1) : addr_q + AddrW'(1);
        if (rem_q == CntW'(1)) begin
          active_q <= 1'b0;
        end
      end
      if (issue) begin
        ov_q <= 1'b1;
        ol_q <= fin_q && (rem_q == CntW'(1));
      end else if (out_m.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_m.valid     = ov_q;
  assign out_m.value_res = rdata_q;
  assign out_m.last_res  = ol_q;

endmodule
